// ===== src/psc_pkg.sv =====
// ----------------------------------------------------------------------------
// psc_pkg: shared types and constants of the payload signature classifier
// Holds the analyser codes, category codes, and the per-signature table.
// It also holds the packet context type that travels between the modules.
// ----------------------------------------------------------------------------
package psc_pkg;

  localparam int unsigned NUM_SIGS   = 14;
  localparam int unsigned OFF_W      = 5;
  localparam int unsigned OP_W       = 4;
  localparam int unsigned CAT_W      = 4;
  localparam logic [OFF_W-1:0] OFF_MAX = 5'd31;

  // Analyser codes, selected by the packet's port.
  localparam logic [OP_W-1:0] OP_FTP21     = 4'd0;
  localparam logic [OP_W-1:0] OP_SMTP25    = 4'd1;
  localparam logic [OP_W-1:0] OP_POP110    = 4'd2;
  localparam logic [OP_W-1:0] OP_SOCKS1080 = 4'd3;
  localparam logic [OP_W-1:0] OP_SQL1433   = 4'd4;
  localparam logic [OP_W-1:0] OP_SSH22     = 4'd5;
  localparam logic [OP_W-1:0] OP_IMAP143   = 4'd6;
  localparam logic [OP_W-1:0] OP_NB137     = 4'd7;
  localparam logic [OP_W-1:0] OP_SMB445    = 4'd8;
  localparam logic [OP_W-1:0] OP_P5354     = 4'd9;
  localparam logic [OP_W-1:0] OP_TCP_ANY   = 4'd10;
  localparam logic [OP_W-1:0] OP_UDP_ANY   = 4'd11;

  // Result categories.
  localparam logic [CAT_W-1:0] CAT_NONE       = 4'd0;
  localparam logic [CAT_W-1:0] CAT_FTP        = 4'd1;
  localparam logic [CAT_W-1:0] CAT_SMTP       = 4'd2;
  localparam logic [CAT_W-1:0] CAT_POP3       = 4'd3;
  localparam logic [CAT_W-1:0] CAT_SOCKS5     = 4'd4;
  localparam logic [CAT_W-1:0] CAT_SQL_INSERT = 4'd5;
  localparam logic [CAT_W-1:0] CAT_SQL_DELETE = 4'd6;
  localparam logic [CAT_W-1:0] CAT_SSH        = 4'd7;
  localparam logic [CAT_W-1:0] CAT_IMAP4      = 4'd8;
  localparam logic [CAT_W-1:0] CAT_SHARE      = 4'd9;
  localparam logic [CAT_W-1:0] CAT_P2P        = 4'd10;
  localparam logic [CAT_W-1:0] CAT_HTTP_PROXY = 4'd11;
  localparam logic [CAT_W-1:0] CAT_UPDATER    = 4'd12;

  // Direction condition of a signature.
  localparam logic [1:0] DIR_DN   = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_ANY  = 2'd2;

  // Signature indexes, one alive bit each.
  localparam int unsigned SIG_SMTP       = 0;
  localparam int unsigned SIG_POP3       = 1;
  localparam int unsigned SIG_SOCKS5     = 2;
  localparam int unsigned SIG_SQL_INSERT = 3;
  localparam int unsigned SIG_SQL_DELETE = 4;
  localparam int unsigned SIG_SSH        = 5;
  localparam int unsigned SIG_IMAP4      = 6;
  localparam int unsigned SIG_NB_SHARE   = 7;
  localparam int unsigned SIG_SMB_SHARE  = 8;
  localparam int unsigned SIG_P5354      = 9;
  localparam int unsigned SIG_TCP_PROXY  = 10;
  localparam int unsigned SIG_TCP_P2P    = 11;
  localparam int unsigned SIG_UDP_P2P    = 12;
  localparam int unsigned SIG_UPDATER    = 13;

  localparam logic [NUM_SIGS-1:0] ALIVE_ALL = '1;

  // Per-signature table, lowest index has priority.
  localparam logic [OP_W-1:0] SIG_OP [NUM_SIGS] = '{
    OP_SMTP25, OP_POP110, OP_SOCKS1080, OP_SQL1433, OP_SQL1433, OP_SSH22,
    OP_IMAP143, OP_NB137, OP_SMB445, OP_P5354, OP_TCP_ANY, OP_TCP_ANY,
    OP_UDP_ANY, OP_UDP_ANY
  };
  localparam logic [1:0] SIG_DIR [NUM_SIGS] = '{
    DIR_UP, DIR_UP, DIR_UP, DIR_UP, DIR_UP, DIR_UP, DIR_UP, DIR_UP,
    DIR_UP, DIR_UP, DIR_UP, DIR_DN, DIR_UP, DIR_ANY
  };
  // Smallest offset of the payload's last byte for the signature to count.
  localparam logic [OFF_W-1:0] SIG_MIN [NUM_SIGS] = '{
    5'd3, 5'd3, 5'd0, 5'd18, 5'd18, 5'd2, 5'd6, 5'd7, 5'd7, 5'd29,
    5'd6, 5'd11, 5'd7, 5'd3
  };
  localparam logic [CAT_W-1:0] SIG_CAT [NUM_SIGS] = '{
    CAT_SMTP, CAT_POP3, CAT_SOCKS5, CAT_SQL_INSERT, CAT_SQL_DELETE, CAT_SSH,
    CAT_IMAP4, CAT_SHARE, CAT_SHARE, CAT_P2P, CAT_HTTP_PROXY, CAT_P2P,
    CAT_P2P, CAT_UPDATER
  };

  // Context of the payload in flight, as seen by the current byte.
  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic             dir;
    logic [OFF_W-1:0] offset;
  } pkt_ctx_t;

endpackage

// ===== src/psc_sig_match.sv =====
// ----------------------------------------------------------------------------
// psc_sig_match: per-byte signature compare
// Compares one payload byte at its offset with every signature byte that
// sits at that offset and returns a mask of the signatures that survive.
// ----------------------------------------------------------------------------
module psc_sig_match
  import psc_pkg::*;
(
  input  logic [OFF_W-1:0]    offset,
  input  logic [7:0]          data_byte,
  output logic [NUM_SIGS-1:0] keep
);

  always_comb begin
    keep = ALIVE_ALL;
    case (offset)
      5'd0: begin
        keep[SIG_SMTP]       = (data_byte == 8'h45);
        keep[SIG_POP3]       = (data_byte == 8'h55);
        keep[SIG_SOCKS5]     = (data_byte == 8'h05);
        keep[SIG_SQL_INSERT] = (data_byte == 8'h01);
        keep[SIG_SQL_DELETE] = (data_byte == 8'h01);
        keep[SIG_SSH]        = (data_byte == 8'h53);
        keep[SIG_TCP_PROXY]  = (data_byte == 8'h43);
        keep[SIG_TCP_P2P]    = (data_byte == 8'h00);
        keep[SIG_UDP_P2P]    = (data_byte == 8'h80);
        keep[SIG_UPDATER]    = (data_byte == 8'h00);
      end
      5'd1: begin
        keep[SIG_SMTP]      = (data_byte == 8'h48);
        keep[SIG_POP3]      = (data_byte == 8'h53);
        keep[SIG_SSH]       = (data_byte == 8'h53);
        keep[SIG_TCP_PROXY] = (data_byte == 8'h4F);
        keep[SIG_TCP_P2P]   = (data_byte == 8'h00);
        keep[SIG_UDP_P2P]   = (data_byte == 8'h94);
        keep[SIG_UPDATER]   = (data_byte == 8'h00);
      end
      5'd2: begin
        keep[SIG_SMTP]      = (data_byte == 8'h4C);
        keep[SIG_POP3]      = (data_byte == 8'h45);
        keep[SIG_SSH]       = (data_byte == 8'h48);
        keep[SIG_IMAP4]     = (data_byte == 8'h4C);
        keep[SIG_TCP_PROXY] = (data_byte == 8'h4E);
        keep[SIG_TCP_P2P]   = (data_byte == 8'h00);
        keep[SIG_UPDATER]   = (data_byte == 8'h03);
      end
      5'd3: begin
        keep[SIG_SMTP]      = (data_byte == 8'h4F);
        keep[SIG_POP3]      = (data_byte == 8'h52);
        keep[SIG_IMAP4]     = (data_byte == 8'h4F);
        keep[SIG_TCP_PROXY] = (data_byte == 8'h4E);
        keep[SIG_UPDATER]   = (data_byte == 8'hF5);
      end
      5'd4: begin
        keep[SIG_IMAP4]     = (data_byte == 8'h47);
        keep[SIG_TCP_PROXY] = (data_byte == 8'h45);
        keep[SIG_UDP_P2P]   = (data_byte == 8'h04);
      end
      5'd5: begin
        keep[SIG_IMAP4]     = (data_byte == 8'h49);
        keep[SIG_NB_SHARE]  = (data_byte == 8'h53);
        keep[SIG_SMB_SHARE] = (data_byte == 8'h53);
        keep[SIG_TCP_PROXY] = (data_byte == 8'h43);
        keep[SIG_TCP_P2P]   = (data_byte == 8'h00);
        keep[SIG_UDP_P2P]   = (data_byte == 8'h29);
      end
      5'd6: begin
        keep[SIG_IMAP4]     = (data_byte == 8'h4E);
        keep[SIG_NB_SHARE]  = (data_byte == 8'h4D);
        keep[SIG_SMB_SHARE] = (data_byte == 8'h4D);
        keep[SIG_TCP_PROXY] = (data_byte == 8'h54);
        keep[SIG_TCP_P2P]   = (data_byte == 8'h00);
        keep[SIG_UDP_P2P]   = (data_byte == 8'h00);
      end
      5'd7: begin
        keep[SIG_NB_SHARE]  = (data_byte == 8'h42);
        keep[SIG_SMB_SHARE] = (data_byte == 8'h42);
        keep[SIG_TCP_P2P]   = (data_byte == 8'h00);
        keep[SIG_UDP_P2P]   = (data_byte == 8'h00);
      end
      5'd8: begin
        keep[SIG_SQL_INSERT] = (data_byte == 8'h49);
        keep[SIG_SQL_DELETE] = (data_byte == 8'h44);
        keep[SIG_TCP_P2P]    = (data_byte == 8'h03);
      end
      5'd9: begin
        keep[SIG_TCP_P2P] = (data_byte == 8'h30);
      end
      5'd10: begin
        keep[SIG_SQL_INSERT] = (data_byte == 8'h4E);
        keep[SIG_SQL_DELETE] = (data_byte == 8'h45);
        keep[SIG_TCP_P2P]    = (data_byte == 8'h68);
      end
      5'd11: begin
        keep[SIG_TCP_P2P] = (data_byte == 8'h73);
      end
      5'd12: begin
        keep[SIG_SQL_INSERT] = (data_byte == 8'h53);
        keep[SIG_SQL_DELETE] = (data_byte == 8'h4C);
      end
      5'd14: begin
        keep[SIG_SQL_INSERT] = (data_byte == 8'h45);
        keep[SIG_SQL_DELETE] = (data_byte == 8'h45);
      end
      5'd16: begin
        keep[SIG_SQL_INSERT] = (data_byte == 8'h52);
        keep[SIG_SQL_DELETE] = (data_byte == 8'h54);
      end
      5'd18: begin
        keep[SIG_SQL_INSERT] = (data_byte == 8'h54);
        keep[SIG_SQL_DELETE] = (data_byte == 8'h45);
      end
      5'd26: keep[SIG_P5354] = (data_byte == 8'h50);
      5'd27: keep[SIG_P5354] = (data_byte == 8'h4F);
      5'd28: keep[SIG_P5354] = (data_byte == 8'h43);
      5'd29: keep[SIG_P5354] = (data_byte == 8'h4F);
      default: keep = ALIVE_ALL;
    endcase
  end

endmodule

// ===== src/psc_category.sv =====
// ----------------------------------------------------------------------------
// psc_category: final category selection
// Picks the first surviving signature of the packet's analyser that meets
// its direction condition and minimum length. The FTP analyser always hits.
// ----------------------------------------------------------------------------
module psc_category
  import psc_pkg::*;
(
  input  pkt_ctx_t            ctx,
  input  logic [NUM_SIGS-1:0] alive,
  output logic [CAT_W-1:0]    category
);

  logic [NUM_SIGS-1:0] hit;

  always_comb begin
    for (int s = 0; s < NUM_SIGS; s++) begin
      hit[s] = alive[s]
             && (SIG_OP[s] == ctx.op)
             && ((SIG_DIR[s] == DIR_ANY) || (SIG_DIR[s] == {1'b0, ctx.dir}))
             && (ctx.offset >= SIG_MIN[s]);
    end
  end

  // Scan from the highest index down so the lowest hit wins.
  always_comb begin
    category = CAT_NONE;
    for (int s = NUM_SIGS - 1; s >= 0; s--) begin
      if (hit[s]) begin
        category = SIG_CAT[s];
      end
    end
    if (ctx.op == OP_FTP21) begin
      category = CAT_FTP;
    end
  end

endmodule

// ===== src/payload_signature_classifier_top.sv =====
// ----------------------------------------------------------------------------
// payload_signature_classifier_top: byte-stream protocol classifier
// Classifies one packet payload per run of bytes and reports one category.
// ----------------------------------------------------------------------------
// Usage:
// The in_ channel carries one payload byte per request in in_tdata. in_tuser
// carries the analyser code and the packet direction; only the values that
// come with the first byte of a payload count. in_tlast marks the payload's
// final byte. Every byte is compared against the fixed-offset signatures of
// all analysers at once, and a running alive mask remembers which still hold.
// On the final byte one request leaves on the out_ channel with the category
// (zero when nothing matched); no other byte produces an output request.
// A byte accepted is held in the input register and classified there; on a
// final byte the category is captured in the output register and leaves
// from there on the out_ channel. There is a single input register and a
// single output register in the path; one byte per cycle flows through them
// unless a final byte waits for the output register, as described below.
// Reset clears the offset counter and both valid flags; alive is all ones.
// When the receiver stalls, the result holds in the output register; bytes
// that produce no result keep flowing, and a final byte waits in the input
// register until the output register frees up.
// ----------------------------------------------------------------------------
module payload_signature_classifier_top
  import psc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // Input byte stream.
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic [4:0] in_tuser,   // [3:0] operation, [4] direction
  input  logic       in_tlast,   // last_byte
  // Result stream.
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [3:0] category, [7:4] zero
);

  // Input register stage.
  logic             s1_valid_r, s1_valid_nxt;
  logic [7:0]       s1_byte_r;
  logic [OP_W-1:0]  s1_op_r;
  logic             s1_dir_r;
  logic             s1_last_r;

  // Payload state.
  logic [OFF_W-1:0]    offset_r, offset_nxt;
  logic [NUM_SIGS-1:0] alive_r, alive_nxt;
  logic [OP_W-1:0]     op_r, op_nxt;
  logic                dir_r, dir_nxt;

  // Output register.
  logic             out_valid_r, out_valid_nxt;
  logic [CAT_W-1:0] out_cat_r;

  logic                out_free;
  logic                s1_fire;
  logic                in_fire;
  logic [NUM_SIGS-1:0] keep;
  logic [NUM_SIGS-1:0] alive_upd;
  logic [CAT_W-1:0]    category;
  pkt_ctx_t            ctx;

  // A byte in the input register advances unless it is a final byte and the
  // output register still holds an untaken result.
  assign out_free  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && (!s1_last_r || out_free);
  assign in_tready = !s1_valid_r || s1_fire;
  assign in_fire   = in_tvalid && in_tready;

  // The first byte of a payload supplies the analyser and direction.
  always_comb begin
    ctx.offset = offset_r;
    if (offset_r == '0) begin
      ctx.op  = s1_op_r;
      ctx.dir = s1_dir_r;
    end else begin
      ctx.op  = op_r;
      ctx.dir = dir_r;
    end
  end

  psc_sig_match u_match (
    .offset    (offset_r),
    .data_byte (s1_byte_r),
    .keep      (keep)
  );

  assign alive_upd = alive_r & keep;

  psc_category u_category (
    .ctx      (ctx),
    .alive    (alive_upd),
    .category (category)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    offset_nxt = offset_r;
    alive_nxt  = alive_r;
    op_nxt     = op_r;
    dir_nxt    = dir_r;
    if (s1_fire) begin
      op_nxt  = ctx.op;
      dir_nxt = ctx.dir;
      if (s1_last_r) begin
        offset_nxt = '0;
        alive_nxt  = ALIVE_ALL;
      end else begin
        alive_nxt = alive_upd;
        if (offset_r != OFF_MAX) begin
          offset_nxt = offset_r + 1'b1;
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_fire && s1_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      offset_r    <= '0;
      alive_r     <= ALIVE_ALL;
      op_r        <= '0;
      dir_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      offset_r    <= offset_nxt;
      alive_r     <= alive_nxt;
      op_r        <= op_nxt;
      dir_r       <= dir_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_tdata;
      s1_op_r   <= in_tuser[OP_W-1:0];
      s1_dir_r  <= in_tuser[OP_W];
      s1_last_r <= in_tlast;
    end
    if (s1_fire && s1_last_r) begin
      out_cat_r <= category;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_cat_r};

`ifndef ASSERT_OFF
  a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_last_r |=> (offset_r == '0) && (alive_r == ALIVE_ALL))
    else $error("offset or alive mask not restored after final byte");

  a_offset_step: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && !s1_last_r && (offset_r != OFF_MAX) |=>
      offset_r == $past(offset_r) + 1'b1)
    else $error("byte offset did not advance by one");

  a_result_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(s1_fire && s1_last_r))
    else $error("result produced without a final byte");

  a_category_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[3:0] <= CAT_UPDATER)
    else $error("category code out of range");
`endif

endmodule
